FILE: rtl/lsra_pkg.sv
// Shared types, widths and helpers for the linear scan register allocator.
`default_nettype none

package lsra_pkg;

  localparam int MAX_REGS   = 32;
  localparam int POS_BITS   = 16;
  localparam int IDX_W      = $clog2(MAX_REGS);
  localparam int CNT_W      = $clog2(MAX_REGS + 1);
  localparam int CFG_W      = 6;
  localparam int REG_W      = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;
  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // One active interval.
  typedef struct packed {
    pos_t end_pos;
    pos_t start_pos;
    idx_t phys;
  } entry_t;

  // Commands from the sequencer to the free-register stack.
  typedef struct packed {
    logic restart;
    cnt_t count;
    logic push;
    idx_t push_id;
    logic pop;
  } stack_cmd_t;

  // One result item; new_reg sits in the lowest bits.
  typedef struct packed {
    logic             halted;
    logic [5:0]       peak_used;
    logic             allocated;
    logic [REG_W-1:0] new_reg;
  } result_t;

  // Register count clamped to the number of physical slots.
  function automatic cnt_t eff_count(input logic [CFG_W-1:0] rc);
    if (int'(rc) > MAX_REGS) begin
      return cnt_t'(MAX_REGS);
    end else begin
      return cnt_t'(rc);
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/linear_scan_register_allocator.sv
// Top level of the linear scan register allocator: sequencer, config register, output stage.
// Usage:
//   in_*  : one live interval per transfer. in_tuser = first_interval (restart
//           allocation before this interval). in_tdata = orig_reg, interval_start,
//           interval_end. Intervals arrive sorted by start, then end.
//   out_* : one result per interval: new_reg, allocated, peak_used, halted.
//   cfg_* : write of reg_count; takes effect at reset and at each restart, and the
//           full test always uses the current value. Write only while idle.
// Timing: one interval at a time. With no expiry an interval goes through prepare,
//   a scan of each active entry, resolve, decide and the output load; an empty set
//   skips the scan and resolve, and once halted prepare goes straight to the output
//   load. in_tready returns as the result loads. Each expired interval adds a push,
//   a shift of the entries above it, a prepare and another scan pass; the single
//   compare unit that ranks entries sets this.
// in_tready is high while the sequencer is idle, so the next interval may be taken
//   while the previous result still waits in the output register; if the receiver
//   stalls, a second result holds inside until that register frees up.
// Reset: empty active set, free stack of 32 registers with id 0 on top, peak and
//   halt cleared, reg_count = 32. No clearing pass is needed.
`default_nettype none

module linear_scan_register_allocator import lsra_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,  // [4:0] orig_reg, [20:5] interval_start,
                                                // [36:21] interval_end, rest zero
  input  wire logic                  in_tuser,  // [0] first_interval
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata, // [4:0] new_reg, [5] allocated,
                                                // [11:6] peak_used, [12] halted, rest zero
  // configuration
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_W-1:0]      cfg_wdata  // reg_count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_RESOLVE,
    S_SHIFT,
    S_DECIDE,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] reg_count_r, reg_count_nxt;
  logic [REG_W-1:0] orig_r, orig_nxt;
  pos_t             start_r, start_nxt;
  pos_t             end_r, end_nxt;
  cnt_t             active_size_r, active_size_nxt;
  cnt_t             peak_r, peak_nxt;
  logic             halt_r, halt_nxt;
  idx_t             scan_idx_r, scan_idx_nxt;
  idx_t             sh_idx_r, sh_idx_nxt;
  logic             found_r, found_nxt;
  idx_t             best_idx_r, best_idx_nxt;
  entry_t           best_r, best_nxt;
  result_t          res_r, res_nxt;
  result_t          out_res_r, out_res_nxt;
  logic             out_valid_r, out_valid_nxt;

  // datapath links
  stack_cmd_t       stack_cmd;
  cnt_t             free_size;
  idx_t             top_id;
  logic             as_wr_en;
  idx_t             as_wr_idx;
  entry_t           as_wr_data;
  idx_t             as_rd_idx;
  entry_t           as_rd_data;
  logic             better;
  logic             in_xfer;
  logic             set_full;
  cnt_t             size_plus;
  cnt_t             sh_next;

  lsra_cmp u_cmp (
    .cand_end   (as_rd_data.end_pos),
    .cand_start (as_rd_data.start_pos),
    .best_end   (best_r.end_pos),
    .best_start (best_r.start_pos),
    .best_valid (found_r),
    .limit      (start_r),
    .better     (better)
  );

  lsra_active_set u_active (
    .clk     (clk),
    .wr_en   (as_wr_en),
    .wr_idx  (as_wr_idx),
    .wr_data (as_wr_data),
    .rd_idx  (as_rd_idx),
    .rd_data (as_rd_data)
  );

  lsra_free_stack u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (stack_cmd),
    .free_size (free_size),
    .top_id    (top_id)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_res_r);

  always_comb begin
    state_nxt       = state_r;
    reg_count_nxt   = cfg_wen ? cfg_wdata : reg_count_r;
    orig_nxt        = orig_r;
    start_nxt       = start_r;
    end_nxt         = end_r;
    active_size_nxt = active_size_r;
    peak_nxt        = peak_r;
    halt_nxt        = halt_r;
    scan_idx_nxt    = scan_idx_r;
    sh_idx_nxt      = sh_idx_r;
    found_nxt       = found_r;
    best_idx_nxt    = best_idx_r;
    best_nxt        = best_r;
    res_nxt         = res_r;
    out_res_nxt     = out_res_r;
    out_valid_nxt   = out_valid_r;

    stack_cmd       = '0;
    stack_cmd.count = eff_count(reg_count_r);
    stack_cmd.push_id = best_r.phys;

    sh_next    = cnt_t'(sh_idx_r) + cnt_t'(1);
    size_plus  = active_size_r + cnt_t'(1);
    set_full   = (active_size_r >= eff_count(reg_count_r)) || (free_size == '0);

    as_wr_en   = 1'b0;
    as_wr_idx  = sh_idx_r;
    as_wr_data = as_rd_data;

    // drop the result once the receiver takes it
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          orig_nxt  = in_tdata[4:0];
          start_nxt = pos_t'(in_tdata[20:5]);
          end_nxt   = pos_t'(in_tdata[36:21]);
          if (in_tuser) begin
            // restart: empty the active set, refill the stack, clear peak and halt
            stack_cmd.restart = 1'b1;
            active_size_nxt   = '0;
            peak_nxt          = '0;
            halt_nxt          = 1'b0;
          end
          state_nxt = S_PREP;
        end
      end

      S_PREP: begin
        found_nxt    = 1'b0;
        scan_idx_nxt = '0;
        if (halt_r) begin
          res_nxt   = '{halted: 1'b1, peak_used: 6'(peak_r), allocated: 1'b0,
                        new_reg: orig_r};
          state_nxt = S_DONE;
        end else if (active_size_r == '0) begin
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // one active entry per cycle through the shared compare unit
        if (better) begin
          found_nxt    = 1'b1;
          best_idx_nxt = scan_idx_r;
          best_nxt     = as_rd_data;
        end
        if (cnt_t'(scan_idx_r) == active_size_r - cnt_t'(1)) begin
          state_nxt = S_RESOLVE;
        end else begin
          scan_idx_nxt = scan_idx_r + idx_t'(1);
        end
      end

      S_RESOLVE: begin
        if (found_r) begin
          // return the register; the stack ignores a push when full
          stack_cmd.push = 1'b1;
          sh_idx_nxt     = best_idx_r;
          state_nxt      = S_SHIFT;
        end else begin
          state_nxt = S_DECIDE;
        end
      end

      S_SHIFT: begin
        // close the gap one slot per cycle, keeping arrival order
        if (sh_next < active_size_r) begin
          as_wr_en   = 1'b1;
          sh_idx_nxt = idx_t'(sh_next);
        end else begin
          active_size_nxt = active_size_r - cnt_t'(1);
          state_nxt       = S_PREP;
        end
      end

      S_DECIDE: begin
        if (set_full) begin
          halt_nxt = 1'b1;
          res_nxt  = '{halted: 1'b1, peak_used: 6'(peak_r), allocated: 1'b0,
                       new_reg: orig_r};
        end else if (start_r != end_r) begin
          stack_cmd.pop   = 1'b1;
          as_wr_en        = 1'b1;
          as_wr_idx       = idx_t'(active_size_r);
          as_wr_data      = '{end_pos: end_r, start_pos: start_r, phys: top_id};
          active_size_nxt = size_plus;
          if (size_plus > peak_r) begin
            peak_nxt = size_plus;
          end
          res_nxt = '{halted: 1'b0,
                      peak_used: (size_plus > peak_r) ? 6'(size_plus) : 6'(peak_r),
                      allocated: 1'b1, new_reg: REG_W'(top_id)};
        end else begin
          // zero-length interval keeps its own id
          res_nxt = '{halted: 1'b0, peak_used: 6'(peak_r), allocated: 1'b0,
                      new_reg: orig_r};
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // fetch the slot the next cycle needs: the next scan slot, else the one above the
    // shift point
    as_rd_idx = (state_nxt == S_SCAN) ? scan_idx_nxt : idx_t'(sh_idx_nxt + idx_t'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      reg_count_r   <= CFG_RESET;
      active_size_r <= '0;
      peak_r        <= '0;
      halt_r        <= 1'b0;
      found_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      reg_count_r   <= reg_count_nxt;
      active_size_r <= active_size_nxt;
      peak_r        <= peak_nxt;
      halt_r        <= halt_nxt;
      found_r       <= found_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    orig_r     <= orig_nxt;
    start_r    <= start_nxt;
    end_r      <= end_nxt;
    scan_idx_r <= scan_idx_nxt;
    sh_idx_r   <= sh_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    res_r      <= res_nxt;
    out_res_r  <= out_res_nxt;
  end

  // Registers are conserved: free plus active never exceeds the slot count. While the
  // gap closes, the returned register already counts as free.
  a_reg_conservation: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SHIFT) |->
      (((CNT_W+1)'(free_size) + (CNT_W+1)'(active_size_r)) <= (CNT_W+1)'(MAX_REGS)))
    else $error("free and active registers exceed the slot count");

  // The peak never falls below the live active set size.
  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= active_size_r)
    else $error("peak below active set size");

  // An accepted interval takes the sequencer busy on the next cycle.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input taken again without processing");

  // A halted result never reports an allocation.
  a_halt_no_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[5] && out_tdata[12]))
    else $error("allocation reported while halted");

endmodule

`default_nettype wire

FILE: rtl/lsra_cmp.sv
// Shared compare unit: tests one active entry for expiry and ranks it against the best so far.
`default_nettype none

module lsra_cmp import lsra_pkg::*; (
  input  wire pos_t cand_end,
  input  wire pos_t cand_start,
  input  wire pos_t best_end,
  input  wire pos_t best_start,
  input  wire logic best_valid,
  input  wire pos_t limit,
  output logic      better
);

  logic eligible;
  logic ranks_lower;

  // Strict compares keep the earliest arrival on a full tie.
  always_comb begin
    eligible    = (cand_end <= limit);
    ranks_lower = (cand_end < best_end) ||
                  ((cand_end == best_end) && (cand_start < best_start));
    better      = eligible && (!best_valid || ranks_lower);
  end

endmodule

`default_nettype wire

FILE: rtl/lsra_active_set.sv
// Active interval register file: one registered read port and one write port per cycle.
`default_nettype none

module lsra_active_set import lsra_pkg::*; (
  input  wire logic   clk,
  input  wire logic   wr_en,
  input  wire idx_t   wr_idx,
  input  wire entry_t wr_data,
  input  wire idx_t   rd_idx,
  output entry_t      rd_data
);

  entry_t slots [MAX_REGS];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_idx] <= wr_data;
    end
    rd_data_r <= slots[rd_idx];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: rtl/lsra_free_stack.sv
// Free-register stack with a low-water mark that stands in for a refill sweep.
`default_nettype none

module lsra_free_stack import lsra_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire stack_cmd_t cmd,
  output cnt_t            free_size,
  output idx_t            top_id
);

  idx_t stack_mem [MAX_REGS];

  cnt_t size_r, size_nxt;
  cnt_t low_r, low_nxt;   // entries below this were not written since restart
  cnt_t base_r, base_nxt; // count taken at the last restart
  idx_t top_r;            // id on top of the stack, fetched ahead from the next stack size
  cnt_t top_pos;
  cnt_t next_top_pos;
  cnt_t next_init;
  logic push_ok;

  always_comb begin
    top_pos  = size_r - cnt_t'(1);
    push_ok  = cmd.push && (int'(size_r) < MAX_REGS);

    size_nxt = size_r;
    low_nxt  = low_r;
    base_nxt = base_r;
    if (cmd.restart) begin
      size_nxt = cmd.count;
      low_nxt  = cmd.count;
      base_nxt = cmd.count;
    end else if (push_ok) begin
      size_nxt = size_r + cnt_t'(1);
    end else if (cmd.pop) begin
      size_nxt = top_pos;
      if (top_pos < low_r) begin
        low_nxt = top_pos;
      end
    end

    next_top_pos = size_nxt - cnt_t'(1);
    next_init    = base_nxt - cnt_t'(1) - next_top_pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= eff_count(CFG_RESET);
      low_r  <= eff_count(CFG_RESET);
      base_r <= eff_count(CFG_RESET);
      top_r  <= '0;  // id 0 on top of a full stack
    end else begin
      size_r <= size_nxt;
      low_r  <= low_nxt;
      base_r <= base_nxt;
      // untouched entries hold their restart value; a push lands on top directly
      if (next_top_pos < low_nxt) begin
        top_r <= idx_t'(next_init);
      end else if (!cmd.restart && push_ok) begin
        top_r <= cmd.push_id;
      end else begin
        top_r <= stack_mem[idx_t'(next_top_pos)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd.restart && push_ok) begin
      stack_mem[idx_t'(size_r)] <= cmd.push_id;
    end
  end

  assign free_size = size_r;
  assign top_id    = top_r;

endmodule

`default_nettype wire
